// File: rtl/core/open_addressing_hash_table_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Types and codes shared by the open addressing hash table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned PrbW   = 11;
  localparam int unsigned LiveW  = 10;

  localparam logic [1:0] FUNC_INSERT   = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_RETRIEVE = 2'd2;

  localparam logic [1:0] MODE_LINEAR    = 2'd0;
  localparam logic [1:0] MODE_DOUBLE    = 2'd1;
  localparam logic [1:0] MODE_QUADRATIC = 2'd2;

  localparam logic [0:0] REG_PROBE_MODE = 1'd0;
  localparam logic [0:0] REG_TABLE_SIZE = 1'd1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_RESERVED  = 3'd6;

  typedef struct packed {
    logic [1:0]       func;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DataW-1:0] data_out;
    logic [PrbW-1:0]  probes;
    logic [LiveW-1:0] stored_keys;
    logic [10:0]      deleted_slots;
  } rsp_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;       // capture request, start divider
    logic div_step;   // one restoring divide step
    logic div_fix;    // divide step of second pass: remainder of quotient
    logic probe_init; // set home slot and step
    logic rd;         // issue key/data read at current slot
    logic eval;       // evaluate returned slot key
    logic advance;    // move to next probe slot
    logic commit;     // apply write and counters, build result
    logic reserved;   // build reserved-key result
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic key_rsv;
    logic div_done;
    logic stop;       // hit, empty or count reached
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: clear sweep, division, probe loop, commit and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           clr_done_i,
  output logic           clr_busy_o,
  output oaht_pkg::cmd_t cmd_o,
  input  oaht_pkg::sts_t sts_i
);
  import oaht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       acc;

  assign clr_busy_o  = (state_q == S_CLEAR);
  assign in_stall_o  = !((state_q == S_IDLE) ||
                         ((state_q == S_OUT) && !out_stall_i));
  assign out_valid_o = (state_q == S_OUT);
  assign acc         = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_done_i) state_d = S_IDLE;
      end
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && !out_stall_i) state_d = S_IDLE;
        if (acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.key_rsv) begin
          cmd_o.reserved = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_done) state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.div_fix = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.stop) begin
          cmd_o.commit = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: request capture, bit-serial divider, probe address, slot stores,
// counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_dp #(
  parameter int unsigned TableDepth = 1024,
  parameter int unsigned KeyBits    = 32,
  parameter int unsigned DataBits   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [10:0]          cfg_wdata_i,
  input  logic [1:0]           func_i,
  input  logic [KeyBits-1:0]   key_i,
  input  logic [DataBits-1:0]  data_i,
  input  logic                 clr_busy_i,
  output logic                 clr_done_o,
  input  oaht_pkg::cmd_t       cmd_i,
  output oaht_pkg::sts_t       sts_o,
  output logic [2:0]           status_o,
  output logic [DataBits-1:0]  data_out_o,
  output logic [10:0]          probes_o,
  output logic [9:0]           stored_o,
  output logic [10:0]          deleted_o
);
  import oaht_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned MW = $clog2(TableDepth + 1);
  localparam int unsigned CW = $clog2(KeyBits + 1);

  // configuration
  logic [1:0]  mode_q;
  logic [10:0] size_q;
  // request
  logic [1:0]          func_q;
  logic [KeyBits-1:0]  key_q;
  logic [DataBits-1:0] din_q;
  logic [MW-1:0]       m_q;
  // divider
  logic [KeyBits-1:0]  quo_q;
  logic [MW-1:0]       rem_q;
  logic [CW-1:0]       dcnt_q;
  logic [MW-1:0]       home_q;
  // probe
  logic [AW-1:0]       pos_q, tomb_q, step_q;
  logic [MW-1:0]       cnt_q;
  logic                has_tomb_q;
  // counters
  logic [MW-1:0]       live_q, tombs_q;
  logic [AW-1:0]       clr_q;

  logic [MW-1:0] m_sat;
  logic [MW:0]   rsh;
  logic          rge;
  logic [MW-1:0] rnew;

  // size saturation
  always_comb begin
    if ({{(32-11){1'b0}}, size_q} < 32'd2) m_sat = MW'(2);
    else if ({{(32-11){1'b0}}, size_q} > 32'(TableDepth)) m_sat = MW'(TableDepth);
    else m_sat = MW'(size_q);
  end

  // restoring divide step on rem, feeding bits of quo (dividend shifted out)
  always_comb begin
    rsh  = {rem_q, quo_q[KeyBits-1]};
    rge  = (rsh >= {1'b0, m_q});
    rnew = rge ? MW'(rsh - {1'b0, m_q}) : rsh[MW-1:0];
  end

  assign sts_o.key_rsv  = (key_q < KeyBits'(2));
  assign sts_o.div_done = (dcnt_q == CW'(KeyBits - 1));
  assign clr_done_o     = (clr_q == AW'(TableDepth - 1));

  // memories
  logic               kwe, dwe;
  logic [AW-1:0]      kaddr;
  logic [KeyBits-1:0] kwdata, krdata;
  logic [DataBits-1:0] drdata;

  // probe outcome of returned key
  logic is_hit, is_empty, is_tomb, cnt_end;
  assign is_hit   = (krdata == key_q);
  assign is_empty = (krdata == '0);
  assign is_tomb  = (krdata == KeyBits'(1));
  assign cnt_end  = ((cnt_q + MW'(1)) >= m_q);
  assign sts_o.stop = is_hit || is_empty || cnt_end;

  logic         ins_ok;
  logic [AW-1:0] ins_pos;
  logic         tomb_now;
  assign tomb_now = has_tomb_q || is_tomb;
  assign ins_pos  = has_tomb_q ? tomb_q : (is_tomb ? pos_q : pos_q);
  assign ins_ok   = (is_empty || tomb_now) && !((live_q + MW'(1)) >= m_q);

  always_comb begin
    kwe    = 1'b0;
    dwe    = 1'b0;
    kaddr  = pos_q;
    kwdata = key_q;
    if (clr_busy_i) begin
      kwe    = 1'b1;
      kaddr  = clr_q;
      kwdata = '0;
    end else if (cmd_i.commit) begin
      if (func_q == FUNC_INSERT) begin
        if (is_hit) begin
          dwe = 1'b1;
        end else if (ins_ok) begin
          kwe   = 1'b1;
          dwe   = 1'b1;
          kaddr = ins_pos;
        end
      end else if (func_q == FUNC_DELETE && is_hit) begin
        kwe    = 1'b1;
        kwdata = KeyBits'(1);
      end
    end
  end

  oaht_ram #(.Width(KeyBits), .Depth(TableDepth)) u_keys (
    .clk_i(clk_i), .we_i(kwe), .addr_i(kaddr), .wdata_i(kwdata), .rdata_o(krdata)
  );
  oaht_ram #(.Width(DataBits), .Depth(TableDepth)) u_data (
    .clk_i(clk_i), .we_i(dwe), .addr_i(kaddr), .wdata_i(din_q), .rdata_o(drdata)
  );

  // next probe slot, downward with wrap
  logic [AW-1:0] dec;
  logic [MW:0]   nxt;
  always_comb begin
    if (mode_q == MODE_QUADRATIC) dec = cnt_q[AW-1:0] + AW'(1);
    else dec = step_q;
    if ({1'b0, MW'(pos_q)} >= {1'b0, MW'(dec)})
      nxt = {1'b0, MW'(pos_q)} - {1'b0, MW'(dec)};
    else
      nxt = {1'b0, MW'(pos_q)} + {1'b0, m_q} - {1'b0, MW'(dec)};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_i;
      din_q  <= data_i;
      m_q    <= m_sat;
      quo_q  <= key_i;
      rem_q  <= '0;
    end else if (cmd_i.div_step || cmd_i.div_fix) begin
      quo_q <= {quo_q[KeyBits-2:0], rge};
      // second pass starts from a clear remainder
      rem_q <= (cmd_i.div_step && sts_o.div_done) ? '0 : rnew;
    end
    if (cmd_i.div_step && sts_o.div_done) home_q <= rnew;
    if (cmd_i.probe_init) begin
      pos_q      <= home_q[AW-1:0];
      step_q     <= (mode_q == MODE_DOUBLE && rnew != '0) ? rnew[AW-1:0] : AW'(1);
      cnt_q      <= '0;
      has_tomb_q <= 1'b0;
    end
    if (cmd_i.eval && !sts_o.stop) begin
      cnt_q <= cnt_q + MW'(1);
      pos_q <= nxt[AW-1:0];
      if (is_tomb && !has_tomb_q) begin
        has_tomb_q <= 1'b1;
        tomb_q     <= pos_q;
      end
    end
    if (cmd_i.reserved) begin
      status_o   <= ST_RESERVED;
      data_out_o <= '0;
      probes_o   <= '0;
      stored_o   <= live_q[9:0];
      deleted_o  <= 11'(tombs_q);
    end
    if (cmd_i.commit) begin
      probes_o   <= 11'(cnt_q + MW'(1));
      data_out_o <= '0;
      stored_o   <= live_q[9:0];
      deleted_o  <= 11'(tombs_q);
      if (func_q == FUNC_INSERT) begin
        if (is_hit) status_o <= ST_UPDATED;
        else if (!is_empty && !tomb_now) status_o <= ST_EXHAUSTED;
        else if ((live_q + MW'(1)) >= m_q) status_o <= ST_FULL;
        else begin
          status_o <= ST_INSERTED;
          stored_o <= 10'(live_q + MW'(1));
          if (tomb_now) deleted_o <= 11'(tombs_q - MW'(1));
        end
      end else if (is_hit) begin
        status_o   <= ST_FOUND;
        data_out_o <= drdata;
        if (func_q == FUNC_DELETE) begin
          stored_o  <= 10'(live_q - MW'(1));
          deleted_o <= 11'(tombs_q + MW'(1));
        end
      end else begin
        status_o <= ST_NOT_FOUND;
      end
    end
  end

  // a tombstone in the stop slot is first tombstone only if none passed
  // earlier; ins_pos above uses pos_q in both cases for that slot.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      size_q  <= 11'(TableDepth);
      live_q  <= '0;
      tombs_q <= '0;
      clr_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROBE_MODE: mode_q <= cfg_wdata_i[1:0];
          REG_TABLE_SIZE: size_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clr_busy_i) clr_q <= clr_q + AW'(1);
      if (cmd_i.load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        if (sts_o.div_done) begin
          // second pass divides quotient by m for the double step
          dcnt_q <= '0;
        end else begin
          dcnt_q <= dcnt_q + CW'(1);
        end
      end else if (cmd_i.div_fix) begin
        dcnt_q <= dcnt_q + CW'(1);
      end
      if (cmd_i.commit) begin
        if (func_q == FUNC_INSERT) begin
          if (!is_hit && ins_ok) begin
            live_q <= live_q + MW'(1);
            if (tomb_now) tombs_q <= tombs_q - MW'(1);
          end
        end else if (func_q == FUNC_DELETE && is_hit) begin
          live_q  <= live_q - MW'(1);
          tombs_q <= tombs_q + MW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/open_addressing_hash_table_unit.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Open addressing hash table: insert, delete and retrieve with linear, double
// or quadratic probing over a configurable number of slots.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | input     | in_valid_i/stall_o | oaht_pkg::req_t
//  out      | output    | out_valid_o/stall_i| oaht_pkg::rsp_t
//  cfg      | input     | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// After reset a clearing pass writes every key slot empty, during which no
// transfer is accepted. An item then goes through bit-serial division (home
// slot and double-hash step), then a read and an evaluate state per probed slot,
// since the key RAM has a single port. A reserved key skips division and
// probing. The result is held until the out transfer; the next item may be
// accepted in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [10:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  oaht_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output oaht_pkg::rsp_t  out_data_o
);
  import oaht_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic clr_busy, clr_done;

  oaht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .clr_done_i(clr_done), .clr_busy_o(clr_busy), .cmd_o(cmd), .sts_i(sts)
  );

  oaht_dp #(
    .TableDepth(TABLE_DEPTH), .KeyBits(KeyW), .DataBits(DataW)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .func_i(in_data_i.func),
    .key_i(in_data_i.key),
    .data_i(in_data_i.data_in),
    .clr_busy_i(clr_busy), .clr_done_o(clr_done),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(out_data_o.status),
    .data_out_o(out_data_o.data_out),
    .probes_o(out_data_o.probes),
    .stored_o(out_data_o.stored_keys),
    .deleted_o(out_data_o.deleted_slots)
  );

endmodule

`default_nettype wire

// File: rtl/core/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks for the hash table unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "open_addressing_hash_table_unit_defines.svh"

module oaht_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input oaht_pkg::rsp_t out_data_o
);
  import oaht_pkg::*;

  `OAHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result dropped while stalled")
  `OAHT_ASSERT_IMP(a_rsv_probes, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_RESERVED, out_data_o.probes == '0, "reserved key probed")
  `OAHT_ASSERT_IMP(a_found_only, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_FOUND, out_data_o.data_out == '0, "data without hit")
  `OAHT_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o, "result too early")

endmodule

bind open_addressing_hash_table_unit oaht_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

`default_nettype wire
